FILE: rtl/core/i2cbe_pkg.sv
package i2cbe_pkg;

    // Operation codes; the request codes on the input channel use the same values.
    typedef enum logic [2:0] {
        OP_IDLE  = 3'd0,
        OP_START = 3'd1,
        OP_STOP  = 3'd2,
        OP_SEND  = 3'd3,
        OP_RECV  = 3'd4,
        OP_SACK  = 3'd5,
        OP_RACK  = 3'd6
    } t_op;

    // Position inside a three-phase bit slot (data/high/low or high/sample/low).
    typedef enum logic [1:0] {
        SLOT_FIRST  = 2'd0,
        SLOT_SECOND = 2'd1,
        SLOT_THIRD  = 2'd2
    } t_slot;

    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned TICK_W     = 16;
    localparam int unsigned PHASE_W    = 5;

    localparam logic              REG_PHASE_TICKS   = 1'b0;
    localparam logic [TICK_W-1:0] PHASE_TICKS_RESET = 16'd10;

    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] tx_data;
        logic       sda_in;
    } t_req;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_bit;
        logic       cmd_rejected;
    } t_res;

    // Number of pin phases in each command sequence.
    function automatic logic [PHASE_W-1:0] seq_length(t_op op);
        logic [PHASE_W-1:0] len;
        unique case (op)
            OP_START: len = 5'd4;
            OP_STOP:  len = 5'd3;
            OP_SEND:  len = 5'd24;
            OP_RECV:  len = 5'd25;
            OP_SACK:  len = 5'd3;
            OP_RACK:  len = 5'd4;
            default:  len = 5'd1;
        endcase
        return len;
    endfunction

endpackage

FILE: rtl/core/i2cbe_if.sv
interface i2cbe_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] req_type;
    logic [7:0] tx_data;
    logic       sda_in;

    modport source (output valid, output req_type, output tx_data, output sda_in, input ready);
    modport sink   (input valid, input req_type, input tx_data, input sda_in, output ready);
endinterface

interface i2cbe_res_if;
    logic       valid;
    logic       ready;
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_bit;
    logic       cmd_rejected;

    modport source (output valid, output scl_out, output sda_out, output busy_res,
                    output done_res, output rx_byte, output ack_bit, output cmd_rejected,
                    input ready);
    modport sink   (input valid, input scl_out, input sda_out, input busy_res,
                    input done_res, input rx_byte, input ack_bit, input cmd_rejected,
                    output ready);
endinterface

FILE: rtl/core/i2c_master_bit_engine.sv
// Channel   Direction  Payload                                            Accepted when
// i_req     in         req_type[2:0], tx_data[7:0], sda_in                valid && ready
// o_res     out        scl_out, sda_out, busy_res, done_res, rx_byte[7:0],
//                      ack_bit, cmd_rejected                              valid && ready
// APB       in         phase_ticks at byte address 0                      psel && penable
//
// Every request is one tick of the timing base and yields exactly one response.
// An accepted request is held in the input register, and the step logic then writes its
// response register from it; a response thus passes the input register and then the
// response register, and a stall on the response side can hold it between them.
// One request is accepted every cycle while the response side is not stalled; the sequencer
// state (phase, tick count, shift register, pin levels and held results) carries over and updates with each request.
// Reset is synchronous and active low; it releases both lines, clears the
// sequencer and loads phase_ticks with 10. A stalled response holds its register
// and back-pressure reaches i_req.ready in the same cycle, so nothing is dropped.
module i2c_master_bit_engine (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    i2cbe_req_if.sink                           i_req,
    i2cbe_res_if.source                         o_res,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [i2cbe_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [i2cbe_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [i2cbe_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                                pready
);
    import i2cbe_pkg::*;

    logic              r_in_valid;
    t_req              r_in_req;
    logic              core_ready;
    logic [TICK_W-1:0] phase_ticks;
    logic              res_valid;
    t_res              res;

    // The configuration block holds the phase length in ticks.
    i2cbe_cfg u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_phase_ticks (phase_ticks)
    );

    // The input register refills in the same cycle that the core takes its request,
    // so a steady stream of ticks flows through without bubbles.
    assign i_req.ready = !r_in_valid || core_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.valid && i_req.ready) begin
            r_in_valid <= 1'b1;
        end else if (core_ready) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in_req.req_type <= i_req.req_type;
            r_in_req.tx_data  <= i_req.tx_data;
            r_in_req.sda_in   <= i_req.sda_in;
        end
    end

    // The core applies one tick to the sequencer state and registers the response.
    i2cbe_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (r_in_valid),
        .i_req         (r_in_req),
        .i_phase_ticks (phase_ticks),
        .o_ready       (core_ready),
        .o_res_valid   (res_valid),
        .i_res_ready   (o_res.ready),
        .o_res         (res)
    );

    assign o_res.valid        = res_valid;
    assign o_res.scl_out      = res.scl_out;
    assign o_res.sda_out      = res.sda_out;
    assign o_res.busy_res     = res.busy_res;
    assign o_res.done_res     = res.done_res;
    assign o_res.rx_byte      = res.rx_byte;
    assign o_res.ack_bit      = res.ack_bit;
    assign o_res.cmd_rejected = res.cmd_rejected;

endmodule

FILE: rtl/core/i2cbe_cfg.sv
module i2cbe_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [i2cbe_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [i2cbe_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [i2cbe_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                                pready,
    output logic [i2cbe_pkg::TICK_W-1:0]        o_phase_ticks
);
    import i2cbe_pkg::*;

    logic              sel_phase_ticks;
    logic [TICK_W-1:0] r_ticks;
    logic              reg_index;

    // Registers sit on 32-bit word boundaries.
    assign reg_index = paddr[2];
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks <= PHASE_TICKS_RESET;
        end else if (psel && penable && pwrite && (reg_index == REG_PHASE_TICKS)) begin
            r_ticks <= pwdata[TICK_W-1:0];
        end
    end

    // Address decode of the one register, for read data selection.
    assign sel_phase_ticks = (reg_index == REG_PHASE_TICKS);

    always_comb begin
        prdata = '0;
        if (sel_phase_ticks) begin
            prdata = {{(CFG_DATA_W-TICK_W){1'b0}}, r_ticks};
        end
    end

    assign o_phase_ticks = r_ticks;

endmodule

FILE: rtl/core/i2cbe_core.sv
module i2cbe_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  i2cbe_pkg::t_req              i_req,
    input  logic [i2cbe_pkg::TICK_W-1:0] i_phase_ticks,
    output logic                         o_ready,
    output logic                         o_res_valid,
    input  logic                         i_res_ready,
    output i2cbe_pkg::t_res              o_res
);
    import i2cbe_pkg::*;

    t_op                r_op, e_op, n_op;
    logic [PHASE_W-1:0] r_pidx, e_pidx, n_pidx;
    logic [TICK_W-1:0]  r_tc, e_tc, n_tc;
    t_slot              r_slot, e_slot, n_slot;
    logic [7:0]         r_shift, e_shift, a_shift;
    logic               r_scl, a_scl;
    logic               r_sda, a_sda;
    logic [7:0]         r_rx, n_rx;
    logic               r_ack, a_ack;
    logic               r_out_valid;
    t_res               r_res, n_res;

    logic               is_cmd;
    logic               rejected;
    logic               done;
    logic               fire;
    logic [TICK_W-1:0]  plen;
    logic [TICK_W:0]    tc_inc;
    logic [PHASE_W-1:0] pidx_inc;

    assign o_ready = !r_out_valid || i_res_ready;
    assign fire    = i_valid && o_ready;

    // Command entry: an idle engine loads the new sequence, a busy one refuses it.
    always_comb begin
        unique case (i_req.req_type) inside
            OP_START, OP_STOP, OP_SEND, OP_RECV, OP_SACK, OP_RACK: is_cmd = 1'b1;
            default: is_cmd = 1'b0;
        endcase

        e_op     = r_op;
        e_pidx   = r_pidx;
        e_tc     = r_tc;
        e_slot   = r_slot;
        e_shift  = r_shift;
        rejected = 1'b0;
        if (r_op != OP_IDLE) begin
            rejected = is_cmd;
        end else if (is_cmd) begin
            e_op   = t_op'(i_req.req_type);
            e_pidx = '0;
            e_tc   = '0;
            e_slot = SLOT_FIRST;
            case (e_op)
                OP_SEND: e_shift = i_req.tx_data;
                OP_SACK: e_shift = {7'b0, i_req.tx_data[0]};
                default: e_shift = '0;
            endcase
        end
    end

    // Pin action of the current phase, taken on its first tick.
    always_comb begin
        a_scl   = r_scl;
        a_sda   = r_sda;
        a_shift = e_shift;
        a_ack   = r_ack;
        if (e_tc == '0) begin
            unique case (e_op)
                OP_START: begin
                    case (e_pidx)
                        5'd0:    a_sda = 1'b1;
                        5'd1:    a_scl = 1'b1;
                        5'd2:    a_sda = 1'b0;
                        default: a_scl = 1'b0;
                    endcase
                end
                OP_STOP: begin
                    case (e_pidx)
                        5'd0:    a_sda = 1'b0;
                        5'd1:    a_scl = 1'b1;
                        default: a_sda = 1'b1;
                    endcase
                end
                OP_SEND: begin
                    case (e_slot)
                        SLOT_FIRST: begin
                            a_sda   = e_shift[7];
                            a_shift = {e_shift[6:0], 1'b0};
                        end
                        SLOT_SECOND: a_scl = 1'b1;
                        default:     a_scl = 1'b0;
                    endcase
                end
                OP_RECV: begin
                    if (e_pidx == '0) begin
                        a_sda = 1'b1;
                    end else begin
                        case (e_slot)
                            SLOT_FIRST:  a_scl   = 1'b1;
                            SLOT_SECOND: a_shift = {e_shift[6:0], i_req.sda_in};
                            default:     a_scl   = 1'b0;
                        endcase
                    end
                end
                OP_SACK: begin
                    case (e_pidx)
                        5'd0:    a_sda = e_shift[0];
                        5'd1:    a_scl = 1'b1;
                        default: a_scl = 1'b0;
                    endcase
                end
                OP_RACK: begin
                    case (e_pidx)
                        5'd0:    a_sda = 1'b1;
                        5'd1:    a_scl = 1'b1;
                        5'd2:    a_ack = i_req.sda_in;
                        default: a_scl = 1'b0;
                    endcase
                end
                default: begin
                end
            endcase
        end
    end

    // Phase timing and sequence advance.
    always_comb begin
        plen     = (i_phase_ticks == '0) ? {{(TICK_W-1){1'b0}}, 1'b1} : i_phase_ticks;
        tc_inc   = {1'b0, e_tc} + {{TICK_W{1'b0}}, 1'b1};
        pidx_inc = e_pidx + 5'd1;

        n_op   = e_op;
        n_pidx = e_pidx;
        n_tc   = e_tc;
        n_slot = e_slot;
        n_rx   = r_rx;
        done   = 1'b0;
        if (e_op != OP_IDLE) begin
            if (tc_inc >= {1'b0, plen}) begin
                n_tc = '0;
                // In receive, the slot count starts after the SDA release phase.
                if (!(e_op == OP_RECV && e_pidx == '0)) begin
                    case (e_slot)
                        SLOT_FIRST:  n_slot = SLOT_SECOND;
                        SLOT_SECOND: n_slot = SLOT_THIRD;
                        default:     n_slot = SLOT_FIRST;
                    endcase
                end
                if (pidx_inc >= seq_length(e_op)) begin
                    if (e_op == OP_RECV) begin
                        n_rx = a_shift;
                    end
                    n_op   = OP_IDLE;
                    n_pidx = '0;
                    done   = 1'b1;
                end else begin
                    n_pidx = pidx_inc;
                end
            end else begin
                n_tc = tc_inc[TICK_W-1:0];
            end
        end

        n_res.scl_out      = a_scl;
        n_res.sda_out      = a_sda;
        n_res.busy_res     = (n_op != OP_IDLE);
        n_res.done_res     = done;
        n_res.rx_byte      = n_rx;
        n_res.ack_bit      = a_ack;
        n_res.cmd_rejected = rejected;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op        <= OP_IDLE;
            r_pidx      <= '0;
            r_tc        <= '0;
            r_slot      <= SLOT_FIRST;
            r_shift     <= '0;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
            r_rx        <= '0;
            r_ack       <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_op        <= n_op;
                r_pidx      <= n_pidx;
                r_tc        <= n_tc;
                r_slot      <= n_slot;
                r_shift     <= a_shift;
                r_scl       <= a_scl;
                r_sda       <= a_sda;
                r_rx        <= n_rx;
                r_ack       <= a_ack;
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_res <= n_res;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_res;

endmodule
